>>> design/dfsle_pkg.sv
package dfsle_pkg;

    // Identifier width shared by node ids, leader values and config data.
    localparam int ID_BITS        = 10;
    localparam int MODE_BITS      = 3;
    localparam int KIND_BITS      = 3;
    localparam int NUM_PORTS      = 4;
    localparam int PORT_IDX_BITS  = $clog2(NUM_PORTS);
    localparam int NUM_CFG_REGS   = 6;
    localparam int CFG_ADDR_BITS  = $clog2(NUM_CFG_REGS);

    // The two ids of a message or a result; the mode or kind travels in tuser.
    localparam int ITEM_BITS      = 2 * ID_BITS;
    localparam int TDATA_BITS     = ((ITEM_BITS + 7) / 8) * 8;

    typedef logic [ID_BITS-1:0] t_id;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_START    = 0,
        MODE_PROBE    = 1,
        MODE_ALREADY  = 2,
        MODE_PARENT   = 3,
        MODE_ANNOUNCE = 4
    } t_mode;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_PROBE    = 0,
        KIND_ALREADY  = 1,
        KIND_PARENT   = 2,
        KIND_ANNOUNCE = 3,
        KIND_DONE     = 4
    } t_kind;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_OWN_ID       = 0,
        CFG_LEFT_ID      = 1,
        CFG_TOP_ID       = 2,
        CFG_BOTTOM_ID    = 3,
        CFG_RIGHT_ID     = 4,
        CFG_RING_NEXT_ID = 5
    } t_cfg_addr;

    // Neighbor ports in priority order: left, top, bottom, right.
    typedef struct packed {
        t_id                 own_id;
        t_id [NUM_PORTS-1:0] port_id;
        t_id                 ring_next_id;
    } t_cfg;

    typedef struct packed {
        t_id                  best_leader;
        t_id                  parent_node;
        logic [NUM_PORTS-1:0] pending_ports;
    } t_node_state;

    typedef struct packed {
        t_kind kind;
        t_id   destination;
        t_id   payload;
    } t_result;

endpackage

>>> design/dfsle_cfg.sv
module dfsle_cfg
    import dfsle_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic [CFG_ADDR_BITS-1:0] i_addr,
    input  t_id                      i_wr_data,
    output t_cfg                     o_cfg,
    output logic                     o_own_id_wr
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_id       <= ID_BITS'(1);
            r_cfg.port_id      <= '0;
            r_cfg.ring_next_id <= ID_BITS'(1);
        end else if (i_wr_en) begin
            unique case (t_cfg_addr'(i_addr))
                CFG_OWN_ID:       r_cfg.own_id       <= i_wr_data;
                CFG_LEFT_ID:      r_cfg.port_id[0]   <= i_wr_data;
                CFG_TOP_ID:       r_cfg.port_id[1]   <= i_wr_data;
                CFG_BOTTOM_ID:    r_cfg.port_id[2]   <= i_wr_data;
                CFG_RIGHT_ID:     r_cfg.port_id[3]   <= i_wr_data;
                CFG_RING_NEXT_ID: r_cfg.ring_next_id <= i_wr_data;
                default:          ;
            endcase
        end
    end

    // A new own id also reloads the leader and parent state.
    assign o_own_id_wr = i_wr_en && (t_cfg_addr'(i_addr) == CFG_OWN_ID);
    assign o_cfg       = r_cfg;

endmodule

>>> design/dfsle_step.sv
module dfsle_step
    import dfsle_pkg::*;
(
    input  t_cfg                 i_cfg,
    input  t_node_state          i_state,
    input  logic [MODE_BITS-1:0] i_mode,
    input  t_id                  i_sender,
    input  t_id                  i_value,
    output t_node_state          o_next_state,
    output logic                 o_res_valid,
    output t_result              o_result
);

    t_node_state             st;
    logic                    do_explore;
    logic                    has_excl;
    logic                    found;
    logic [PORT_IDX_BITS-1:0] pick;

    always_comb begin
        st          = i_state;
        o_res_valid = 1'b0;
        o_result    = '0;
        do_explore  = 1'b0;
        has_excl    = 1'b0;
        found       = 1'b0;
        pick        = '0;

        unique case (t_mode'(i_mode))
            MODE_START: begin
                do_explore = 1'b1;
            end
            MODE_PROBE: begin
                if (i_value > i_state.best_leader) begin
                    st.best_leader = i_value;
                    st.parent_node = i_sender;
                    for (int i = 0; i < NUM_PORTS; i++) begin
                        if (i_cfg.port_id[i] == i_sender) begin
                            st.pending_ports[i] = 1'b0;
                        end
                    end
                    do_explore = 1'b1;
                    has_excl   = 1'b1;
                end else if (i_value == i_state.best_leader) begin
                    o_res_valid = 1'b1;
                    o_result    = '{KIND_ALREADY, i_sender, i_state.best_leader};
                end
            end
            MODE_ALREADY, MODE_PARENT: begin
                do_explore = (i_value == i_state.best_leader);
            end
            MODE_ANNOUNCE: begin
                o_res_valid = 1'b1;
                if (i_cfg.own_id == i_state.best_leader) begin
                    o_result = '{KIND_DONE, '0, i_state.best_leader};
                end else begin
                    st.best_leader = i_value;
                    o_result = '{KIND_ANNOUNCE, i_cfg.ring_next_id, i_value};
                end
            end
            default: ;
        endcase

        // First pending, present port that is not the sender of the probe.
        for (int i = 0; i < NUM_PORTS; i++) begin
            if (!found && st.pending_ports[i] && (i_cfg.port_id[i] != '0) &&
                !(has_excl && (i_cfg.port_id[i] == i_sender))) begin
                found = 1'b1;
                pick  = PORT_IDX_BITS'(i);
            end
        end

        if (do_explore) begin
            o_res_valid = 1'b1;
            if (found) begin
                st.pending_ports[pick] = 1'b0;
                o_result = '{KIND_PROBE, i_cfg.port_id[pick], st.best_leader};
            end else if (st.parent_node != i_cfg.own_id) begin
                o_result = '{KIND_PARENT, st.parent_node, st.best_leader};
            end else begin
                o_result = '{KIND_ANNOUNCE, i_cfg.ring_next_id, st.best_leader};
            end
        end

        o_next_state = st;
    end

endmodule

>>> design/dfs_max_id_leader_election_node_core.sv
// One node of a depth-first, max-id leader election on a torus.
//
// Slave stream (i_s_*): one message per transaction. Its tuser carries the
// message mode and its tdata the sender id and the carried leader value.
// Master stream (o_m_*): at most one reply per message, with its kind in
// tuser and its destination id and leader payload in tdata. Messages that
// cause no reply simply disappear.
//
// The configuration port writes the own id, the four neighbor ids and the
// next ring node, one register per cycle. The user must write it only while
// the node is idle; the block does not enforce this. Writing the own id
// also resets the best leader and the parent to that id.
// Timing: a message accepted at one clock edge sits in the input register,
// is decided by a single combinational step against the node state, and its
// reply enters the output register on the edge at which the message retires.
// The node state is updated on that same edge, so the following message
// already sees it, and one message is taken every cycle while the receiver
// does not stall. When the receiver stalls, the reply waits in the output
// register while one more message may wait in the input register; after
// that, o_s_tready falls until the output drains.
//
// Reset (synchronous, active low) empties both registers, restores the
// configuration defaults and sets all four ports pending.
module dfs_max_id_leader_election_node_core
    import dfsle_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Slave stream, tuser: mode.
    // tdata from bit 0: sender, value, zero padding.
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [MODE_BITS-1:0]     i_s_tuser,
    input  logic [TDATA_BITS-1:0]    i_s_tdata,
    // Master stream, tuser: kind.
    // tdata from bit 0: destination, payload, zero padding.
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [KIND_BITS-1:0]     o_m_tuser,
    output logic [TDATA_BITS-1:0]    o_m_tdata,
    // Configuration write port.
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  t_id                      i_cfg_wr_data
);

    t_cfg                 cfg;
    logic                 own_id_wr;

    logic                 r_in_valid;
    logic [MODE_BITS-1:0] r_in_mode;
    t_id                  r_in_sender;
    t_id                  r_in_value;

    t_node_state          r_state;
    t_node_state          n_state;
    logic                 res_valid;
    t_result              res;

    logic                 r_out_valid;
    t_result              r_out;

    logic                 out_free;
    logic                 advance;

    dfsle_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (i_cfg_wr_en),
        .i_addr      (i_cfg_addr),
        .i_wr_data   (i_cfg_wr_data),
        .o_cfg       (cfg),
        .o_own_id_wr (own_id_wr)
    );

    dfsle_step u_step (
        .i_cfg        (cfg),
        .i_state      (r_state),
        .i_mode       (r_in_mode),
        .i_sender     (r_in_sender),
        .i_value      (r_in_value),
        .o_next_state (n_state),
        .o_res_valid  (res_valid),
        .o_result     (res)
    );

    // The held message retires when it has no reply or the output register
    // can take its reply in this cycle.
    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && (!res_valid || out_free);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_mode   <= i_s_tuser;
            r_in_sender <= i_s_tdata[ID_BITS-1:0];
            r_in_value  <= i_s_tdata[ID_BITS +: ID_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.best_leader   <= ID_BITS'(1);
            r_state.parent_node   <= ID_BITS'(1);
            r_state.pending_ports <= '1;
        end else if (own_id_wr) begin
            r_state.best_leader <= i_cfg_wr_data;
            r_state.parent_node <= i_cfg_wr_data;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = TDATA_BITS'({r_out.payload, r_out.destination});

endmodule

>>> design/dfsle_checker.sv
module dfsle_checker
    import dfsle_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_s_tready,
    input logic                     o_m_tvalid,
    input logic                     i_m_tready,
    input logic [KIND_BITS-1:0]     o_m_tuser,
    input logic [TDATA_BITS-1:0]    o_m_tdata
);

    logic [KIND_BITS-1:0] out_kind;
    t_id                  out_dest;

    assign out_kind = o_m_tuser;
    assign out_dest = o_m_tdata[ID_BITS-1:0];

    // No reply may appear right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("reply present after reset");

    // The input side is open for a message right after reset.
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_tready)
        else $error("not ready after reset");

    // A stalled reply stays and keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled reply changed");

    // Completion is reported to the coordinator only.
    a_done_to_coord: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (out_kind == KIND_DONE) |-> (out_dest == '0))
        else $error("done sent to a node");

    // A probe never goes to an absent neighbor.
    a_probe_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (out_kind == KIND_PROBE) |-> (out_dest != '0))
        else $error("probe sent to id zero");

endmodule

bind dfs_max_id_leader_election_node_core dfsle_checker u_dfsle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_s_tready    (o_s_tready),
    .o_m_tvalid    (o_m_tvalid),
    .i_m_tready    (i_m_tready),
    .o_m_tuser     (o_m_tuser),
    .o_m_tdata     (o_m_tdata)
);
